>>> sv/scfp_pkg.sv
// Shared types and constants for the serial command frame parser.
// No dependencies; imported by scfp_frame_fsm and serial_command_frame_parser_core.
`default_nettype none

package scfp_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_LINK_MODE     = 2'd0;
    localparam t_reg_idx REG_OWN_ADDRESS   = 2'd1;
    localparam t_reg_idx REG_CHECKSUM_SEED = 2'd2;

    localparam logic       RST_LINK_MODE     = 1'b1;
    localparam logic [7:0] RST_OWN_ADDRESS   = 8'h42;
    localparam logic [7:0] RST_CHECKSUM_SEED = 8'hAA;

    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic       link_mode;
        logic [7:0] own_address;
        logic [7:0] checksum_seed;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  command;
        logic [3:0]  param_count;
        logic [63:0] params;
    } t_frame;

endpackage

`default_nettype wire

>>> sv/serial_command_frame_parser_core.sv
// Serial command frame parser top level: APB registers, parser, output skid stage.
// Depends on scfp_pkg and scfp_frame_fsm.
//
// Usage:
//   Receive channel: i_rx_valid / o_rx_stall / i_rx_byte, one byte per request.
//   Frame channel:   o_frame_valid / i_frame_stall / o_command, o_param_count, o_params.
//   A request is taken on a clock edge with valid high and stall low.
//   Frames look like 'M' 'X' address command size params [checksum].
//   Throughput: one byte per cycle while o_rx_stall is low; each byte is parsed in the cycle it is taken.
//   A frame's last byte loads the output register, or the skid if the output holds.
//   Output side has an output register plus one skid register, so bytes keep
//   flowing while a frame waits; o_rx_stall rises only once the skid is full.
//   Reset (synchronous, active low): parser waits for 'M', output empty,
//   link_mode = checked, own_address = 0x42, checksum_seed = 0xAA.
//   Registers at byte address 0, 4, 8: link_mode, own_address, checksum_seed.
//   Write them only while no frame is in progress.
`default_nettype none

module serial_command_frame_parser_core
    import scfp_pkg::*;
#(
    parameter int MAX_PARAMS = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,

    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  wire                i_rx_valid,
    output logic               o_rx_stall,
    input  wire  [7:0]         i_rx_byte,

    output logic               o_frame_valid,
    input  wire                i_frame_stall,
    output logic [7:0]         o_command,
    output logic [3:0]         o_param_count,
    output logic [63:0]        o_params
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     rx_accept;
    logic     emit;
    t_frame   frame;

    logic     r_out_valid;
    t_frame   r_out;
    logic     r_skid_valid;
    t_frame   r_skid;
    logic     out_free;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_mode     <= RST_LINK_MODE;
            r_cfg.own_address   <= RST_OWN_ADDRESS;
            r_cfg.checksum_seed <= RST_CHECKSUM_SEED;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LINK_MODE:     r_cfg.link_mode     <= pwdata[0];
                REG_OWN_ADDRESS:   r_cfg.own_address   <= pwdata[7:0];
                REG_CHECKSUM_SEED: r_cfg.checksum_seed <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LINK_MODE:     prdata = PDATA_W'(r_cfg.link_mode);
            REG_OWN_ADDRESS:   prdata = PDATA_W'(r_cfg.own_address);
            REG_CHECKSUM_SEED: prdata = PDATA_W'(r_cfg.checksum_seed);
            default:           prdata = '0;
        endcase
    end

    assign o_rx_stall = r_skid_valid;
    assign rx_accept  = i_rx_valid && !r_skid_valid;

    scfp_frame_fsm #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (rx_accept),
        .i_byte   (i_rx_byte),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_frame  (frame)
    );

    // skid is only loaded while output holds; bytes are refused while it is full
    assign out_free = !r_out_valid || !i_frame_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || emit;
            r_skid_valid <= 1'b0;
        end else if (emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : frame;
        end else if (emit) begin
            r_skid <= frame;
        end
    end

    assign o_frame_valid = r_out_valid;
    assign o_command     = r_out.command;
    assign o_param_count = r_out.param_count;
    assign o_params      = r_out.params;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a frame while output is empty");

    a_no_emit_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !r_skid_valid)
        else $error("frame produced while skid register is full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid |-> (o_param_count <= 4'(MAX_PARAMS)))
        else $error("parameter count above maximum");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid |-> ((o_params >> (8 * o_param_count)) == 64'd0))
        else $error("unused parameter bytes not zero");

endmodule

`default_nettype wire

>>> sv/scfp_frame_fsm.sv
// Byte-level frame parser: preamble, address, command, size, parameters, checksum.
// Depends on scfp_pkg; instantiated by serial_command_frame_parser_core.
`default_nettype none

module scfp_frame_fsm
    import scfp_pkg::*;
#(
    parameter int MAX_PARAMS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_accept,
    input  wire  [7:0]  i_byte,
    input  t_cfg        i_cfg,
    output logic        o_emit,
    output t_frame      o_frame
);

    typedef enum logic [2:0] {
        PH_PRE1 = 3'd0,
        PH_PRE2 = 3'd1,
        PH_ADDR = 3'd2,
        PH_CMD  = 3'd3,
        PH_SIZE = 3'd4,
        PH_PARA = 3'd5,
        PH_CHK  = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [3:0]  r_left, n_left;
    logic [3:0]  r_total, n_total;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_store [MAX_PARAMS];
    logic [7:0]  n_store [MAX_PARAMS];
    logic [7:0]  size;
    logic [3:0]  slot;
    logic        emit;

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_left  = r_left;
        n_total = r_total;
        n_check = r_check;
        n_store = r_store;
        emit    = 1'b0;
        size    = i_cfg.link_mode ? i_byte : i_byte - ASCII_ZERO;
        slot    = r_total - r_left;
        if (i_accept) begin
            case (r_phase)
                PH_PRE1: begin
                    if (i_byte == CHAR_M) n_phase = PH_PRE2;
                end
                PH_PRE2: begin
                    n_phase = (i_byte == CHAR_X) ? PH_ADDR : PH_PRE1;
                end
                PH_ADDR: begin
                    n_phase = (i_byte == i_cfg.own_address) ? PH_CMD : PH_PRE1;
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_check = i_cfg.checksum_seed ^ i_byte;
                    for (int k = 0; k < MAX_PARAMS; k++) n_store[k] = '0;
                    n_total = '0;
                    n_left  = '0;
                    n_phase = PH_SIZE;
                end
                PH_SIZE: begin
                    if (size > 8'(MAX_PARAMS)) begin
                        n_phase = PH_PRE1;
                    end else begin
                        n_check = r_check ^ size;
                        n_total = size[3:0];
                        n_left  = size[3:0];
                        if (size != 8'd0) begin
                            n_phase = PH_PARA;
                        end else if (i_cfg.link_mode) begin
                            n_phase = PH_CHK;
                        end else begin
                            n_phase = PH_PRE1;
                            emit    = 1'b1;
                        end
                    end
                end
                PH_PARA: begin
                    if (r_left == 4'd0) begin
                        n_phase = PH_PRE1;
                    end else begin
                        for (int k = 0; k < MAX_PARAMS; k++) begin
                            if (slot == 4'(k)) n_store[k] = i_byte;
                        end
                        n_check = r_check ^ i_byte;
                        n_left  = r_left - 4'd1;
                        if (n_left == 4'd0) begin
                            if (i_cfg.link_mode) begin
                                n_phase = PH_CHK;
                            end else begin
                                n_phase = PH_PRE1;
                                emit    = 1'b1;
                            end
                        end
                    end
                end
                PH_CHK: begin
                    n_phase = PH_PRE1;
                    emit    = ((r_check ^ i_byte) == 8'd0);
                end
                default: begin
                    n_phase = PH_PRE1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE1;
            r_cmd   <= '0;
            r_left  <= '0;
            r_total <= '0;
            r_check <= '0;
            for (int k = 0; k < MAX_PARAMS; k++) r_store[k] <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_left  <= n_left;
            r_total <= n_total;
            r_check <= n_check;
            r_store <= n_store;
        end
    end

    assign o_emit              = emit;
    assign o_frame.command     = n_cmd;
    assign o_frame.param_count = n_total;

    for (genvar g = 0; g < 8; g++) begin : g_pack
        if (g < MAX_PARAMS) begin : g_used
            assign o_frame.params[8*g +: 8] = n_store[g];
        end else begin : g_unused
            assign o_frame.params[8*g +: 8] = 8'd0;
        end
    end

endmodule

`default_nettype wire

>>> sim/scfp_frame_checker.sv
// Frame checker: watches the register port and both request channels of the parser,
// keeps its own parser state and compares every frame leaving the block.
// Depends on scfp_pkg.
module scfp_frame_checker
    import scfp_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,

    input  wire                i_psel,
    input  wire                i_penable,
    input  wire                i_pwrite,
    input  wire                i_pready,
    input  wire  [PADDR_W-1:0] i_paddr,
    input  wire  [PDATA_W-1:0] i_pwdata,

    input  wire                i_rx_valid,
    input  wire                i_rx_stall,
    input  wire  [7:0]         i_rx_byte,

    input  wire                i_frame_valid,
    input  wire                i_frame_stall,
    input  wire  [7:0]         i_command,
    input  wire  [3:0]         i_param_count,
    input  wire  [63:0]        i_params,

    output int                 o_pending,
    output int                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PARAMS = 8;

    typedef enum logic [2:0] {
        WAIT_M,
        WAIT_X,
        WAIT_ADDR,
        WAIT_CMD,
        WAIT_SIZE,
        WAIT_PARAMS,
        WAIT_CHECK
    } t_parse_phase;

    t_cfg         cfg;
    t_parse_phase phase;
    logic [7:0]   held_cmd;
    logic [3:0]   left;
    logic [3:0]   total;
    logic [2:0]   slot;
    logic [7:0]   check;
    logic [7:0]   slots [8];
    t_frame       expected_frames [$];
    int           fails = 0;

    task automatic queue_frame;
        t_frame f;
        f.command     = held_cmd;
        f.param_count = total;
        f.params      = '0;
        for (int k = 0; k < 8; k++) begin
            f.params[8*k +: 8] = slots[k];
        end
        expected_frames.push_back(f);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] count_byte;
        case (phase)
            WAIT_M: begin
                if (b == CHAR_M) phase = WAIT_X;
            end
            WAIT_X: begin
                phase = (b == CHAR_X) ? WAIT_ADDR : WAIT_M;
            end
            WAIT_ADDR: begin
                phase = (b == cfg.own_address) ? WAIT_CMD : WAIT_M;
            end
            WAIT_CMD: begin
                held_cmd = b;
                check    = cfg.checksum_seed ^ b;
                for (int k = 0; k < 8; k++) slots[k] = 8'h00;
                total    = '0;
                left     = '0;
                slot     = '0;
                phase    = WAIT_SIZE;
            end
            WAIT_SIZE: begin
                count_byte = cfg.link_mode ? b : b - ASCII_ZERO;
                if (count_byte > MAX_PARAMS) begin
                    phase = WAIT_M;
                end else begin
                    check = check ^ count_byte;
                    total = count_byte[3:0];
                    left  = count_byte[3:0];
                    slot  = '0;
                    if (count_byte != 0) begin
                        phase = WAIT_PARAMS;
                    end else if (cfg.link_mode) begin
                        phase = WAIT_CHECK;
                    end else begin
                        phase = WAIT_M;
                        queue_frame();
                    end
                end
            end
            WAIT_PARAMS: begin
                if (left == 0) begin
                    phase = WAIT_M;
                end else begin
                    slots[slot] = b;
                    slot  = slot + 3'd1;
                    check = check ^ b;
                    left  = left - 4'd1;
                    if (left == 0) begin
                        if (cfg.link_mode) begin
                            phase = WAIT_CHECK;
                        end else begin
                            phase = WAIT_M;
                            queue_frame();
                        end
                    end
                end
            end
            WAIT_CHECK: begin
                phase = WAIT_M;
                if ((check ^ b) == 8'h00) queue_frame();
            end
            default: begin
                phase = WAIT_M;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame   want;
        t_reg_idx idx;
        if (!i_rst_n) begin
            cfg.link_mode     = RST_LINK_MODE;
            cfg.own_address   = RST_OWN_ADDRESS;
            cfg.checksum_seed = RST_CHECKSUM_SEED;
            phase    = WAIT_M;
            held_cmd = '0;
            left     = '0;
            total    = '0;
            slot     = '0;
            check    = '0;
            for (int k = 0; k < 8; k++) slots[k] = 8'h00;
            expected_frames.delete();
        end else begin
            if (i_frame_valid && !i_frame_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("frame with none expected: command %h count %0d params %h",
                           i_command, i_param_count, i_params);
                    fails++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_command !== want.command) begin
                        $error("command: expected %h, got %h", want.command, i_command);
                        fails++;
                    end
                    if (i_param_count !== want.param_count) begin
                        $error("param_count: expected %0d, got %0d",
                               want.param_count, i_param_count);
                        fails++;
                    end
                    if (i_params !== want.params) begin
                        $error("params: expected %h, got %h", want.params, i_params);
                        fails++;
                    end
                end
            end
            // a byte taken on the same edge as a register write still sees the old value
            if (i_rx_valid && !i_rx_stall) parse_byte(i_rx_byte);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = i_paddr[3:2];
                case (idx)
                    REG_LINK_MODE:     cfg.link_mode     = i_pwdata[0];
                    REG_OWN_ADDRESS:   cfg.own_address   = i_pwdata[7:0];
                    REG_CHECKSUM_SEED: cfg.checksum_seed = i_pwdata[7:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/tb_serial_command_frame_parser_core.sv
// Testbench top for serial_command_frame_parser_core: clock, reset, register writes,
// byte stimulus with random gaps and output stalls, final verdict.
// Depends on scfp_pkg, serial_command_frame_parser_core and scfp_frame_checker.
module tb_serial_command_frame_parser_core;
    import scfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PARAMS  = 8;
    localparam int CYCLE_LIMIT = 300000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_rx_valid    = 1'b0;
    logic               o_rx_stall;
    logic [7:0]         i_rx_byte     = 8'h00;
    logic               o_frame_valid;
    logic               i_frame_stall = 1'b0;
    logic [7:0]         o_command;
    logic [3:0]         o_param_count;
    logic [63:0]        o_params;

    int         pending;
    int         fail_count;
    int         cycle_count = 0;
    int         rx_sent     = 0;
    bit         rx_gaps     = 1'b0;
    bit         sink_gaps   = 1'b0;
    logic       cur_mode    = RST_LINK_MODE;
    logic [7:0] cur_addr    = RST_OWN_ADDRESS;
    logic [7:0] cur_seed    = RST_CHECKSUM_SEED;

    serial_command_frame_parser_core #(.MAX_PARAMS(MAX_PARAMS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_frame_valid (o_frame_valid),
        .i_frame_stall (i_frame_stall),
        .o_command     (o_command),
        .o_param_count (o_param_count),
        .o_params      (o_params)
    );

    scfp_frame_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_rx_valid    (i_rx_valid),
        .i_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .i_frame_valid (o_frame_valid),
        .i_frame_stall (i_frame_stall),
        .i_command     (o_command),
        .i_param_count (o_param_count),
        .i_params      (o_params),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output-side stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_gaps && $urandom_range(0, 2) == 0) begin
                i_frame_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_frame_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINK_MODE:     cur_mode = val[0];
            REG_OWN_ADDRESS:   cur_addr = val;
            REG_CHECKSUM_SEED: cur_seed = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic mode, input logic [7:0] addr,
                              input logic [7:0] seed);
        write_reg(REG_LINK_MODE, {7'h0, mode});
        write_reg(REG_OWN_ADDRESS, addr);
        write_reg(REG_CHECKSUM_SEED, seed);
    endtask

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = (rx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        rx_sent++;
    endtask

    // stop sending, let every expected frame out, then allow for the output latency
    task automatic wait_drain;
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_header(input logic [7:0] cmd);
        push_byte(CHAR_M);
        push_byte(CHAR_X);
        push_byte(cur_addr);
        push_byte(cmd);
    endtask

    // fill < 0 gives random parameter bytes
    task automatic send_frame(input logic [7:0] cmd, input int n, input int fill,
                              input bit bad_sum);
        logic [7:0] chk;
        logic [7:0] p;
        chk = cur_seed ^ cmd ^ n[7:0];
        send_header(cmd);
        push_byte(cur_mode ? n[7:0] : ASCII_ZERO + n[7:0]);
        repeat (n) begin
            p = (fill < 0) ? 8'($urandom) : fill[7:0];
            chk = chk ^ p;
            push_byte(p);
        end
        if (cur_mode) push_byte(bad_sum ? chk ^ 8'($urandom_range(1, 255)) : chk);
    endtask

    task automatic run_phase(input int n_bytes);
        int stop_at;
        int kind;
        int n;
        stop_at = rx_sent + n_bytes;
        while (rx_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            n = ($urandom_range(0, 5) == 0) ? MAX_PARAMS : $urandom_range(0, MAX_PARAMS);
            if (kind < 13) begin
                send_frame(8'($urandom), n, -1, 1'b0);
            end else if (kind < 15) begin
                send_frame(8'($urandom), n, -1, 1'b1);
            end else if (kind == 15) begin
                send_header(8'($urandom));
                if (cur_mode)
                    push_byte(8'($urandom_range(MAX_PARAMS + 1, 255)));
                else if ($urandom_range(0, 1) == 0)
                    push_byte(8'($urandom_range(0, 8'h2F)));
                else
                    push_byte(8'($urandom_range(8'h39, 255)));
            end else if (kind == 16) begin
                push_byte(CHAR_M);
                push_byte(CHAR_X);
                push_byte(cur_addr ^ 8'($urandom_range(1, 255)));
            end else if (kind == 17) begin
                push_byte(CHAR_M);
                push_byte(($urandom_range(0, 1) == 0) ? CHAR_M : 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_byte(($urandom_range(0, 3) == 0) ? CHAR_M : 8'($urandom));
            end
        end
        wait_drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: checked link at reset settings
        rx_gaps   = 1'b1;
        sink_gaps = 1'b1;
        send_frame(8'hFF, 0, 0, 1'b0);
        send_frame(8'h00, MAX_PARAMS, 8'hFF, 1'b0);
        send_frame(8'hA5, 3, -1, 1'b1);
        send_header(8'h00);
        push_byte(8'(MAX_PARAMS + 1));
        push_byte(CHAR_M);
        push_byte(CHAR_M);
        push_byte(CHAR_X);
        push_byte(CHAR_M);
        push_byte(CHAR_X);
        push_byte(cur_addr + 8'd1);
        // checksum phase reached, then link switched to wired
        send_header(8'h3C);
        push_byte(8'h00);
        wait_drain();
        write_reg(REG_LINK_MODE, 8'h00);
        push_byte(cur_seed ^ 8'h3C);

        // directed: wired link
        send_frame(8'h12, 0, -1, 1'b0);
        send_frame(8'h34, MAX_PARAMS, 8'h00, 1'b0);
        send_header(8'h56);
        push_byte(ASCII_ZERO - 8'd1);
        send_header(8'h56);
        push_byte(ASCII_ZERO + 8'(MAX_PARAMS + 1));
        // parameters in progress, then link switched to checked
        send_header(8'h77);
        push_byte(ASCII_ZERO + 8'd2);
        push_byte(8'h11);
        wait_drain();
        write_reg(REG_LINK_MODE, 8'h01);
        push_byte(8'h22);
        push_byte(cur_seed ^ 8'h77 ^ 8'h02 ^ 8'h11 ^ 8'h22);
        wait_drain();

        set_config(1'b1, 8'h00, 8'h00);
        run_phase(320);
        rx_gaps   = 1'b0;
        sink_gaps = 1'b0;
        set_config(1'b0, 8'hFF, 8'hFF);
        run_phase(320);
        rx_gaps   = 1'b1;
        set_config(1'b1, 8'hFF, 8'($urandom));
        run_phase(320);
        rx_gaps   = 1'b0;
        sink_gaps = 1'b1;
        set_config(1'b0, 8'h00, 8'($urandom));
        run_phase(320);
        rx_gaps   = 1'b1;
        set_config(1'($urandom), 8'($urandom), 8'($urandom));
        run_phase(320);
        rx_gaps   = 1'b0;
        sink_gaps = 1'b0;
        set_config(1'b1, CHAR_M, 8'($urandom));
        run_phase(300);

        repeat (2) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
